// ===== hw/rtl/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; every other RTL file of the block imports this package.
`default_nettype none

package wsd_pkg;

    // Width of the payload length counter; longer lengths saturate.
    localparam int unsigned LEN_W = 64;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // Header decode constants.
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] MASK_BYTES = 4'd4;

    // Result queue between the parser and the output port.
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    // Parser phases, one-hot.
    typedef enum logic [6:0] {
        PH_IDLE = 7'b0000001,
        PH_HDR1 = 7'b0000010,
        PH_EXT2 = 7'b0000100,
        PH_EXT8 = 7'b0001000,
        PH_MASK = 7'b0010000,
        PH_DATA = 7'b0100000,
        PH_DONE = 7'b1000000
    } t_phase;

    // One result item.
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       fin_flag;
        logic [3:0] frame_opcode;
        logic       was_masked;
        logic       last;
        logic       header_error;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/wsd_parse.sv =====
// Front part of the deframer: header parser and payload unmasking.
// Depends on wsd_pkg; pushes at most one result per accepted byte.
`default_nettype none

module wsd_parse (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_frame_start,
    output wsd_pkg::t_result     o_result,
    output logic                 o_push
);
    import wsd_pkg::*;

    t_phase           r_phase, n_phase;
    logic             r_fin, n_fin;
    logic [3:0]       r_opcode, n_opcode;
    logic             r_mask, n_mask;
    logic [3:0]       r_hcount, n_hcount;
    logic [LEN_W-1:0] r_remain, n_remain;
    logic [31:0]      r_key, n_key;
    logic [1:0]       r_idx, n_idx;

    logic [3:0]       w_hcount_inc;
    logic [LEN_W-1:0] w_ext_len;
    logic [7:0]       w_key_byte;

    assign w_hcount_inc = r_hcount + 4'd1;

    // Saturating big-endian accumulation of the extended length.
    assign w_ext_len = (|r_remain[LEN_W-1 -: 8]) ? LEN_MAX
                                                  : {r_remain[LEN_W-9:0], i_data_byte};

    // The first key byte received masks payload index 0.
    always_comb begin
        case (r_idx)
            2'd0:    w_key_byte = r_key[31:24];
            2'd1:    w_key_byte = r_key[23:16];
            2'd2:    w_key_byte = r_key[15:8];
            default: w_key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_fin    = r_fin;
        n_opcode = r_opcode;
        n_mask   = r_mask;
        n_hcount = r_hcount;
        n_remain = r_remain;
        n_key    = r_key;
        n_idx    = r_idx;
        o_push   = 1'b0;
        o_result = '0;
        o_result.fin_flag     = r_fin;
        o_result.frame_opcode = r_opcode;
        if (i_accept) begin
            if (i_frame_start) begin
                if (r_phase == PH_HDR1) begin
                    o_push = 1'b1;
                    o_result.header_error = 1'b1;
                end
                n_fin    = i_data_byte[7];
                n_opcode = i_data_byte[3:0];
                n_mask   = 1'b0;
                n_hcount = '0;
                n_remain = '0;
                n_key    = '0;
                n_idx    = '0;
                n_phase  = PH_HDR1;
            end else begin
                case (r_phase)
                    PH_HDR1: begin
                        n_mask   = i_data_byte[7];
                        n_hcount = '0;
                        n_remain = '0;
                        if (i_data_byte[6:0] == LEN7_EXT16) begin
                            n_phase = PH_EXT2;
                        end else if (i_data_byte[6:0] == LEN7_EXT64) begin
                            n_phase = PH_EXT8;
                        end else begin
                            n_remain = LEN_W'(i_data_byte[6:0]);
                            n_idx    = '0;
                            if (i_data_byte[7]) begin
                                n_phase = PH_MASK;
                            end else if (i_data_byte[6:0] == 7'd0) begin
                                n_phase = PH_DONE;
                                o_push  = 1'b1;
                                o_result.last = 1'b1;
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end
                    end
                    PH_EXT2, PH_EXT8: begin
                        n_remain = w_ext_len;
                        n_hcount = w_hcount_inc;
                        if (w_hcount_inc >= ((r_phase == PH_EXT2) ? EXT16_BYTES
                                                                  : EXT64_BYTES)) begin
                            n_hcount = '0;
                            n_idx    = '0;
                            if (r_mask) begin
                                n_phase = PH_MASK;
                            end else if (w_ext_len == '0) begin
                                n_phase = PH_DONE;
                                o_push  = 1'b1;
                                o_result.last = 1'b1;
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end
                    end
                    PH_MASK: begin
                        n_key    = {r_key[23:0], i_data_byte};
                        n_hcount = w_hcount_inc;
                        if (w_hcount_inc >= MASK_BYTES) begin
                            n_hcount = '0;
                            n_idx    = '0;
                            if (r_remain == '0) begin
                                n_phase = PH_DONE;
                                o_push  = 1'b1;
                                o_result.last       = 1'b1;
                                o_result.was_masked = r_mask;
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end
                    end
                    PH_DATA: begin
                        n_idx = r_idx + 2'd1;
                        if (r_remain != '0) begin
                            n_remain = r_remain - LEN_W'(1);
                        end
                        o_push = 1'b1;
                        o_result.payload_valid = 1'b1;
                        o_result.was_masked    = r_mask;
                        o_result.payload_byte  = r_mask ? (i_data_byte ^ w_key_byte)
                                                        : i_data_byte;
                        if (r_remain <= LEN_W'(1)) begin
                            o_result.last = 1'b1;
                            n_phase = PH_DONE;
                        end
                    end
                    default: begin
                        // Bytes outside a frame are dropped.
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_fin    <= 1'b0;
            r_opcode <= '0;
            r_mask   <= 1'b0;
            r_hcount <= '0;
            r_remain <= '0;
            r_key    <= '0;
            r_idx    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_fin    <= n_fin;
            r_opcode <= n_opcode;
            r_mask   <= n_mask;
            r_hcount <= n_hcount;
            r_remain <= n_remain;
            r_key    <= n_key;
            r_idx    <= n_idx;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/wsd_fifo.sv =====
// Back part of the deframer: a small result queue that drives the output port.
// Depends on wsd_pkg for the result type and the queue depth.
`default_nettype none

module wsd_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wsd_pkg::t_result     i_data,
    input  wire logic            i_pop,
    output wsd_pkg::t_result     o_data,
    output logic                 o_empty,
    output logic                 o_full
);
    import wsd_pkg::*;

    t_result          r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CNT_W'(FIFO_DEPTH));
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_do_push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = w_do_pop ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/websocket_frame_deframer.sv =====
// WebSocket frame deframer top level: byte parser in front, result queue behind.
// Throughput: one byte per cycle unless the queue is full; each result is registered.
// The four-entry result queue lets the input keep flowing while the output is stalled.
// Input stalls only when that queue is full; the parser itself never holds a byte.
// Reset is synchronous and active low; it clears parser state and empties the queue.
// Depends on wsd_pkg, wsd_parse and wsd_fifo.
`default_nettype none

module websocket_frame_deframer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Input channel: one frame byte per transfer.
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_frame_start,
    // Output channel: one result item per transfer.
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_payload_byte,
    output logic            o_payload_valid,
    output logic            o_fin_flag,
    output logic [3:0]      o_frame_opcode,
    output logic            o_was_masked,
    output logic            o_last,
    output logic            o_header_error
);
    import wsd_pkg::*;

    logic    w_in_accept;
    logic    w_push;
    logic    w_empty;
    logic    w_full;
    t_result w_parse_result;
    t_result w_out_result;

    // The parser consumes every byte the moment it is accepted, so the only
    // reason to stall the input is a full queue: each byte pushes at most one
    // result, and a non-full queue always has room for it.
    assign o_stall     = w_full;
    assign w_in_accept = i_valid && !w_full;

    wsd_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_in_accept),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .o_result      (w_parse_result),
        .o_push        (w_push)
    );

    // The queue head is the output register; a transfer on the output side
    // pops it, and a push and a pop may happen in the same cycle.
    wsd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_parse_result),
        .i_pop   (!i_stall),
        .o_data  (w_out_result),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    assign o_valid         = !w_empty;
    assign o_payload_byte  = w_out_result.payload_byte;
    assign o_payload_valid = w_out_result.payload_valid;
    assign o_fin_flag      = w_out_result.fin_flag;
    assign o_frame_opcode  = w_out_result.frame_opcode;
    assign o_was_masked    = w_out_result.was_masked;
    assign o_last          = w_out_result.last;
    assign o_header_error  = w_out_result.header_error;

`ifndef SYNTHESIS
    // A result is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("result pushed into a full queue");

    // Results without data carry a zero byte.
    a_empty_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_payload_valid) |-> (o_payload_byte == 8'd0))
        else $error("non-data result carries a payload byte");

    // A header error never comes with payload or end of payload.
    a_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_header_error) |-> (!o_payload_valid && !o_last && !o_was_masked))
        else $error("header error result carries payload flags");

    // Reset leaves the output channel empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire
